/* rtl/particle_update_engine_core_assert.svh */
// Assertion macros shared by the particle update engine RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PARTICLE_UPDATE_ENGINE_CORE_ASSERT_SVH
`define PARTICLE_UPDATE_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PUE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define PUE_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define PUE_ASSERT(lbl, clk, rst, prop)
`define PUE_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* rtl/pue_pkg.sv */
// Shared types, constants and arithmetic helpers of the particle update engine.
// No dependencies; used by every module of the block.
package pue_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOT_W        = 6;
   localparam int POS_W         = 18;
   localparam int VEL_W         = 12;
   localparam int PIX_W         = 9;
   localparam int COLOR_W       = 16;
   localparam int LIFE_W        = 8;
   localparam int HUE_W         = 8;
   localparam int V_W           = 17;
   localparam int DIV_NUM_W     = 24;
   localparam int DIV_DEN_W     = 8;
   localparam int DIV_STEP_W    = $clog2(DIV_NUM_W);
   localparam int REQ_DATA_W    = 80;
   localparam int REQ_USER_W    = 1;
   localparam int RSP_DATA_W    = 64;
   localparam int RSP_USER_W    = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 9;

   // ceil(2^31 / 255); exact floor(p / 255) for p up to 65536 * 255
   localparam logic [DIV_NUM_W-1:0] RECIP_255 = 24'h808081;
   localparam int                   RECIP_SH  = 31;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRAVITY_STEP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRAG_HORIZ    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRAG_VERT     = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SP_SCAN,
      ST_TK_SCAN,
      ST_TK_LOAD,
      ST_TK_WB,
      ST_TK_DIVV,
      ST_TK_PROD,
      ST_TK_XST,
      ST_TK_EMIT,
      ST_TK_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_SPAWN_OK,
      OUT_PEND_MORE,
      OUT_PEND_LAST
   } out_sel_type;

   typedef struct packed {
      logic        req_load;
      logic        mem_read;
      logic        upd_load;
      logic        spawn_write;
      logic        upd_write;
      logic        v_start;
      logic        v_latch;
      logic        prod_load;
      logic        x_latch;
      logic        pend_load;
      logic        pend_clear;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic func_tick;
      logic slot_live;
      logic kill;
      logic out_free;
      logic div_busy;
      logic div_done;
      logic pend_valid;
   } stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [VEL_W-1:0]  vx;
      logic [VEL_W-1:0]  vy;
      logic [LIFE_W-1:0] life;
      logic [LIFE_W-1:0] max_life;
      logic [HUE_W-1:0]  hue;
   } entry_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W:0] s);
      logic [POS_W-1:0] r;
      if (s > 19'sd131071) begin
         r = 18'h1FFFF;
      end else if (s < -19'sd131072) begin
         r = 18'h20000;
      end else begin
         r = s[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [VEL_W-1:0] sat_vel(input logic signed [13:0] s);
      logic [VEL_W-1:0] r;
      if (s > 14'sd2047) begin
         r = 12'h7FF;
      end else if (s < -14'sd2048) begin
         r = 12'h800;
      end else begin
         r = s[VEL_W-1:0];
      end
      return r;
   endfunction

   // Q8 position to pixel, truncated toward zero, clamped to the 9 bit range
   function automatic logic [PIX_W-1:0] pixel(input logic [POS_W-1:0] q);
      logic signed [POS_W:0] a;
      logic signed [10:0]    p;
      logic [PIX_W-1:0]      r;
      a = $signed({q[POS_W-1], q});
      if (q[POS_W-1]) begin
         a = a + 19'sd255;
      end
      p = a[POS_W:8];
      if (p > 11'sd255) begin
         r = 9'h0FF;
      end else if (p < -11'sd256) begin
         r = 9'h100;
      end else begin
         r = p[PIX_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [10:0] hue_h6(input logic [HUE_W-1:0] hue);
      logic [10:0] h;
      h = 11'(hue) * 11'd6;
      if (h == 11'd1530) begin
         h = '0;
      end
      return h;
   endfunction

   function automatic logic [2:0] hue_sector(input logic [HUE_W-1:0] hue);
      logic [10:0] h;
      logic [2:0]  s;
      h = hue_h6(hue);
      priority if (h >= 11'd1275) s = 3'd5;
      else if (h >= 11'd1020)     s = 3'd4;
      else if (h >= 11'd765)      s = 3'd3;
      else if (h >= 11'd510)      s = 3'd2;
      else if (h >= 11'd255)      s = 3'd1;
      else                        s = 3'd0;
      return s;
   endfunction

   // 255 - |t - 255| with t = h6 mod 510
   function automatic logic [7:0] hue_weight(input logic [HUE_W-1:0] hue);
      logic [10:0] h;
      logic [10:0] t;
      logic [10:0] d;
      h = hue_h6(hue);
      priority if (h >= 11'd1020) t = h - 11'd1020;
      else if (h >= 11'd510)      t = h - 11'd510;
      else                        t = h;
      d = (t > 11'd255) ? (t - 11'd255) : (11'd255 - t);
      return 8'(11'd255 - d);
   endfunction

   function automatic logic [7:0] to_byte(input logic [17:0] ch);
      logic [16:0] c;
      logic [24:0] p;
      c = (ch > 18'd65536) ? 17'd65536 : ch[16:0];
      p = 25'(c) * 25'd255;
      return p[23:16];
   endfunction

   function automatic logic [COLOR_W-1:0] color565(input logic [V_W-1:0] v,
                                                  input logic [V_W-1:0] x,
                                                  input logic [2:0] sector);
      logic [V_W-1:0] r;
      logic [V_W-1:0] g;
      logic [V_W-1:0] b;
      logic [18:0]    v5;
      logic [V_W-1:0] boost;
      logic [7:0]     rb;
      logic [7:0]     gb;
      logic [7:0]     bb;
      case (sector)
         3'd0:    begin r = v;  g = x;  b = '0; end
         3'd1:    begin r = x;  g = v;  b = '0; end
         3'd2:    begin r = '0; g = v;  b = x;  end
         3'd3:    begin r = '0; g = x;  b = v;  end
         3'd4:    begin r = x;  g = '0; b = v;  end
         default: begin r = v;  g = '0; b = x;  end
      endcase
      v5 = 19'(v) * 19'd5;
      boost = (v5 > 19'd262144) ? 17'(v5 - 19'd262144) : '0;
      rb = to_byte(18'(r) + 18'(boost));
      gb = to_byte(18'(g) + 18'(boost));
      bb = to_byte(18'(b) + 18'(boost));
      return {rb[7:3], gb[7:2], bb[7:3]};
   endfunction

endpackage

/* rtl/particle_update_engine_core.sv */
// Particle table with motion, gravity, drag and HSV fade colouring to RGB565 segments.
// A spawn request takes the lowest free slot, searching the slots in order from slot 0.
// A tick request walks every slot: a free slot is skipped, a particle that leaves the
// screen is written back and freed, and a survivor also runs the one-bit-per-cycle
// divider that forms the fade life/max_life (the hue channel /255 is a reciprocal
// multiply); the walk also stalls while the output register waits on rsp_tready.
// Results leave through that register, the last one marked by rsp_tlast.
// No clearing pass is needed after reset. Depends on pue_pkg, pue_ctrl, pue_dp, pue_div.
module particle_update_engine_core #(
   parameter int SLOTS = pue_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // spawn_x, spawn_y, spawn_vx, spawn_vy, spawn_life, spawn_hue, zero pad
   input  logic [pue_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic [pue_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot, line_x0, line_y0, line_x1, line_y1, color, zero pad
   output logic [pue_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // segment_valid, spawn_accepted
   output logic [pue_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pue_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pue_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   pue_pkg::cmd_type  cmd;
   pue_pkg::stat_type stat;
   logic [IW-1:0]     idx;

   assign csr_ready = 1'b1;

   pue_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd),
      .idx       (idx)
   );

   pue_dp #(.SLOTS(SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .idx        (idx),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/pue_div.sv */
// Restoring divider, one quotient bit per cycle, used for the fade life/max_life.
// Depends on pue_pkg.
module pue_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pue_pkg::DIV_NUM_W-1:0]     num,
   input  logic [pue_pkg::DIV_DEN_W-1:0]     den,
   output logic [pue_pkg::DIV_NUM_W-1:0]     quo,
   output pue_pkg::div_stat_type             stat
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [pue_pkg::DIV_STEP_W-1:0]       step_ff, step_in;
   logic [pue_pkg::DIV_DEN_W-1:0]        rem_ff, rem_in;
   logic [pue_pkg::DIV_DEN_W-1:0]        den_ff, den_in;
   logic [pue_pkg::DIV_NUM_W-1:0]        quo_ff, quo_in;
   logic [pue_pkg::DIV_DEN_W:0]          trial;
   logic                                 ge;

   assign trial = {rem_ff, quo_ff[pue_pkg::DIV_NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = pue_pkg::DIV_STEP_W'(pue_pkg::DIV_NUM_W - 1);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? pue_pkg::DIV_DEN_W'(trial - {1'b0, den_ff})
                     : trial[pue_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[pue_pkg::DIV_NUM_W-2:0], ge};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/pue_ctrl.sv */
// Sequencer of the particle update engine: slot walk, spawn search and result order.
// Depends on pue_pkg and the assertion macro header.
`include "particle_update_engine_core_assert.svh"

module pue_ctrl #(
   parameter  int SLOTS = pue_pkg::SLOTS_DEFAULT,
   localparam int CW    = $clog2(SLOTS + 1),
   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pue_pkg::stat_type   stat,
   output pue_pkg::cmd_type    cmd,
   output logic [IW-1:0]       idx
);

   pue_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               cnt_clr;
   logic               cnt_inc;
   logic               at_end;

   assign at_end = cnt_ff == CW'(SLOTS);
   assign idx    = cnt_ff[IW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pue_pkg::ST_IDLE: begin
            if (req_valid) state_in = pue_pkg::ST_DISPATCH;
         end
         pue_pkg::ST_DISPATCH: begin
            state_in = stat.func_tick ? pue_pkg::ST_TK_SCAN : pue_pkg::ST_SP_SCAN;
         end
         pue_pkg::ST_SP_SCAN: begin
            if ((at_end || !stat.slot_live) && stat.out_free) state_in = pue_pkg::ST_IDLE;
         end
         pue_pkg::ST_TK_SCAN: begin
            if (at_end) begin
               state_in = pue_pkg::ST_TK_FLUSH;
            end else if (stat.slot_live) begin
               state_in = pue_pkg::ST_TK_LOAD;
            end
         end
         pue_pkg::ST_TK_LOAD: state_in = pue_pkg::ST_TK_WB;
         pue_pkg::ST_TK_WB: begin
            state_in = stat.kill ? pue_pkg::ST_TK_SCAN : pue_pkg::ST_TK_DIVV;
         end
         pue_pkg::ST_TK_DIVV: begin
            if (stat.div_done) state_in = pue_pkg::ST_TK_PROD;
         end
         pue_pkg::ST_TK_PROD: state_in = pue_pkg::ST_TK_XST;
         pue_pkg::ST_TK_XST:  state_in = pue_pkg::ST_TK_EMIT;
         pue_pkg::ST_TK_EMIT: begin
            if (!stat.pend_valid || stat.out_free) state_in = pue_pkg::ST_TK_SCAN;
         end
         pue_pkg::ST_TK_FLUSH: begin
            if (stat.out_free) state_in = pue_pkg::ST_IDLE;
         end
         default: state_in = pue_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cnt_clr   = 1'b0;
      cnt_inc   = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         pue_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_load = req_valid;
            cnt_clr      = 1'b1;
         end
         pue_pkg::ST_DISPATCH: ;
         pue_pkg::ST_SP_SCAN: begin
            if (at_end) begin
               if (stat.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = pue_pkg::OUT_NONE;
               end
            end else if (!stat.slot_live) begin
               if (stat.out_free) begin
                  cmd.spawn_write = 1'b1;
                  cmd.out_load    = 1'b1;
                  cmd.out_sel     = pue_pkg::OUT_SPAWN_OK;
               end
            end else begin
               cnt_inc = 1'b1;
            end
         end
         pue_pkg::ST_TK_SCAN: begin
            if (!at_end) begin
               if (stat.slot_live) cmd.mem_read = 1'b1;
               else                cnt_inc      = 1'b1;
            end
         end
         pue_pkg::ST_TK_LOAD: cmd.upd_load = 1'b1;
         pue_pkg::ST_TK_WB: begin
            cmd.upd_write = 1'b1;
            if (stat.kill) cnt_inc     = 1'b1;
            else           cmd.v_start = 1'b1;
         end
         pue_pkg::ST_TK_DIVV: cmd.v_latch   = stat.div_done;
         pue_pkg::ST_TK_PROD: cmd.prod_load = 1'b1;
         pue_pkg::ST_TK_XST:  cmd.x_latch   = 1'b1;
         pue_pkg::ST_TK_EMIT: begin
            if (!stat.pend_valid || stat.out_free) begin
               cmd.pend_load = 1'b1;
               cnt_inc       = 1'b1;
               if (stat.pend_valid) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = pue_pkg::OUT_PEND_MORE;
               end
            end
         end
         pue_pkg::ST_TK_FLUSH: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.pend_clear = 1'b1;
               cmd.out_sel    = stat.pend_valid ? pue_pkg::OUT_PEND_LAST : pue_pkg::OUT_NONE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      priority if (cnt_clr) cnt_in = '0;
      else if (cnt_inc)     cnt_in = cnt_ff + 1'b1;
      else                  cnt_in = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pue_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `PUE_ASSERT(a_out_load_free, clock, reset, cmd.out_load |-> stat.out_free)
   `PUE_ASSERT(a_div_start_idle, clock, reset, cmd.v_start |-> !stat.div_busy)
   `PUE_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CW'(SLOTS))
   `PUE_ASSERT(a_req_only_idle, clock, reset, cmd.req_load |=> (state_ff == pue_pkg::ST_DISPATCH))

endmodule

/* rtl/pue_dp.sv */
// Datapath: config registers, particle memory, motion update, colour, result registers.
// Depends on pue_pkg and pue_div.
module pue_dp #(
   parameter  int SLOTS = pue_pkg::SLOTS_DEFAULT,
   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pue_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [pue_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                csr_valid,
   input  logic [pue_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [pue_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [IW-1:0]                       idx,
   input  pue_pkg::cmd_type                    cmd,
   output pue_pkg::stat_type                   stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pue_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [pue_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);

   // configuration
   logic [7:0] sw_ff, sh_ff, grav_ff;
   logic [8:0] dragh_ff, dragv_ff;

   // captured request
   logic                       func_ff;
   logic [16:0]                sx_ff, sy_ff;
   logic [pue_pkg::VEL_W-1:0]  svx_ff, svy_ff;
   logic [pue_pkg::LIFE_W-1:0] slife_ff;
   logic [pue_pkg::HUE_W-1:0]  shue_ff;

   // particle store
   pue_pkg::entry_type mem_ff [SLOTS];
   pue_pkg::entry_type rd_ff;
   pue_pkg::entry_type wr_data;
   logic               wr_en;
   logic [SLOTS-1:0]   live_ff;

   // motion update
   logic [pue_pkg::POS_W-1:0]  ux_ff, uy_ff, ux_in, uy_in;
   logic [pue_pkg::VEL_W-1:0]  uvx_ff, uvy_ff, uvx_in, uvy_in;
   logic [pue_pkg::LIFE_W-1:0] ulife_ff;
   logic signed [pue_pkg::POS_W:0] sum_x, sum_y;
   logic signed [12:0]         vyg_raw;
   logic [pue_pkg::VEL_W-1:0]  vyg;
   logic signed [21:0]         mvx, mvy;
   logic                       kill;

   // colour
   logic [pue_pkg::V_W-1:0]        v_ff, xq_ff, v_in;
   logic [pue_pkg::DIV_NUM_W-1:0]  prod_ff;
   logic [24:0]                    prod_full;
   logic [2*pue_pkg::DIV_NUM_W-1:0] xq_full;
   logic [pue_pkg::DIV_NUM_W-1:0]  div_num, div_quo;
   logic [pue_pkg::DIV_DEN_W-1:0]  div_den;
   pue_pkg::div_stat_type          div_stat;

   // pending and output results
   logic                          pend_valid_ff;
   logic [pue_pkg::SLOT_W-1:0]    pend_slot_ff;
   logic [pue_pkg::PIX_W-1:0]     pend_x0_ff, pend_y0_ff, pend_x1_ff, pend_y1_ff;
   logic [pue_pkg::COLOR_W-1:0]   pend_color_ff;
   logic                          rsp_valid_ff;
   logic [pue_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pue_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff    <= 8'd160;
         sh_ff    <= 8'd128;
         grav_ff  <= 8'd10;
         dragh_ff <= 9'd243;
         dragv_ff <= 9'd246;
      end else if (csr_valid) begin
         case (csr_addr)
            pue_pkg::CSR_SCREEN_WIDTH:  sw_ff    <= csr_wdata[7:0];
            pue_pkg::CSR_SCREEN_HEIGHT: sh_ff    <= csr_wdata[7:0];
            pue_pkg::CSR_GRAVITY_STEP:  grav_ff  <= csr_wdata[7:0];
            pue_pkg::CSR_DRAG_HORIZ:    dragh_ff <= csr_wdata;
            pue_pkg::CSR_DRAG_VERT:     dragv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         func_ff  <= req_tuser[0];
         sx_ff    <= req_tdata[16:0];
         sy_ff    <= req_tdata[33:17];
         svx_ff   <= req_tdata[45:34];
         svy_ff   <= req_tdata[57:46];
         slife_ff <= req_tdata[65:58];
         shue_ff  <= req_tdata[73:66];
      end
   end

   // motion step on the entry just read
   assign sum_x   = $signed({rd_ff.x[pue_pkg::POS_W-1], rd_ff.x})
                  + $signed({{7{rd_ff.vx[pue_pkg::VEL_W-1]}}, rd_ff.vx});
   assign sum_y   = $signed({rd_ff.y[pue_pkg::POS_W-1], rd_ff.y})
                  + $signed({{7{rd_ff.vy[pue_pkg::VEL_W-1]}}, rd_ff.vy});
   assign vyg_raw = $signed({rd_ff.vy[pue_pkg::VEL_W-1], rd_ff.vy}) + $signed({5'b0, grav_ff});
   assign vyg     = pue_pkg::sat_vel({vyg_raw[12], vyg_raw});
   assign mvx     = $signed(rd_ff.vx) * $signed({1'b0, dragh_ff});
   assign mvy     = $signed(vyg) * $signed({1'b0, dragv_ff});
   assign ux_in   = pue_pkg::sat_pos(sum_x);
   assign uy_in   = pue_pkg::sat_pos(sum_y);
   assign uvx_in  = pue_pkg::sat_vel(mvx[21:8]);
   assign uvy_in  = pue_pkg::sat_vel(mvy[21:8]);

   always_ff @(posedge clock) begin
      if (cmd.upd_load) begin
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         uvx_ff   <= uvx_in;
         uvy_ff   <= uvy_in;
         ulife_ff <= rd_ff.life - 1'b1;
      end
   end

   assign kill = ux_ff[pue_pkg::POS_W-1]
              || ($signed(ux_ff) >= $signed({2'b00, sw_ff, 8'h00}))
              || ($signed(uy_ff) >= $signed({2'b00, sh_ff, 8'h00}));

   always_comb begin
      wr_en   = cmd.spawn_write || cmd.upd_write;
      wr_data = rd_ff;
      priority if (cmd.spawn_write) begin
         wr_data.x        = {sx_ff[16], sx_ff};
         wr_data.y        = {sy_ff[16], sy_ff};
         wr_data.vx       = svx_ff;
         wr_data.vy       = svy_ff;
         wr_data.life     = slife_ff;
         wr_data.max_life = slife_ff;
         wr_data.hue      = shue_ff;
      end else begin
         wr_data.x    = ux_ff;
         wr_data.y    = uy_ff;
         wr_data.vx   = uvx_ff;
         wr_data.vy   = uvy_ff;
         wr_data.life = ulife_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[idx] <= wr_data;
      if (cmd.mem_read) rd_ff <= mem_ff[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (cmd.spawn_write) begin
         live_ff[idx] <= slife_ff != '0;
      end else if (cmd.upd_write) begin
         live_ff[idx] <= !kill && (ulife_ff != '0);
      end
   end

   // fade = life / max_life on the divider
   assign div_num = {ulife_ff, 16'h0000};
   assign div_den = rd_ff.max_life;

   pue_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.v_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   always_comb begin
      priority if (rd_ff.max_life == '0)  v_in = '0;
      else if (ulife_ff >= rd_ff.max_life) v_in = 17'd65536;
      else                                 v_in = div_quo[pue_pkg::V_W-1:0];
   end

   // second channel V * w / 255, the /255 by reciprocal multiply
   assign prod_full = 25'(v_ff) * 25'(pue_pkg::hue_weight(rd_ff.hue));
   assign xq_full   = (2*pue_pkg::DIV_NUM_W)'(prod_ff)
                    * (2*pue_pkg::DIV_NUM_W)'(pue_pkg::RECIP_255);

   always_ff @(posedge clock) begin
      if (cmd.v_latch)   v_ff    <= v_in;
      if (cmd.prod_load) prod_ff <= prod_full[pue_pkg::DIV_NUM_W-1:0];
      if (cmd.x_latch)   xq_ff   <= xq_full[pue_pkg::RECIP_SH +: pue_pkg::V_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pend_load) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.pend_clear) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_slot_ff  <= pue_pkg::SLOT_W'(idx);
         pend_x0_ff    <= pue_pkg::pixel(rd_ff.x);
         pend_y0_ff    <= pue_pkg::pixel(rd_ff.y);
         pend_x1_ff    <= pue_pkg::pixel(ux_ff);
         pend_y1_ff    <= pue_pkg::pixel(uy_ff);
         pend_color_ff <= pue_pkg::color565(v_ff, xq_ff, pue_pkg::hue_sector(rd_ff.hue));
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_data_in = '0;
      rsp_user_in = '0;
      rsp_last_in = 1'b1;
      unique case (cmd.out_sel)
         pue_pkg::OUT_NONE: ;
         pue_pkg::OUT_SPAWN_OK: begin
            rsp_data_in[pue_pkg::SLOT_W-1:0] = pue_pkg::SLOT_W'(idx);
            rsp_user_in = 2'b10;
         end
         pue_pkg::OUT_PEND_MORE, pue_pkg::OUT_PEND_LAST: begin
            rsp_data_in = {6'b0, pend_color_ff, pend_y1_ff, pend_x1_ff,
                           pend_y0_ff, pend_x0_ff, pend_slot_ff};
            rsp_user_in = 2'b01;
            rsp_last_in = cmd.out_sel == pue_pkg::OUT_PEND_LAST;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign stat.func_tick  = func_ff;
   assign stat.slot_live  = live_ff[idx];
   assign stat.kill       = kill;
   assign stat.out_free   = out_free;
   assign stat.div_busy   = div_stat.busy;
   assign stat.div_done   = div_stat.done;
   assign stat.pend_valid = pend_valid_ff;

endmodule
